[design/lcs_pkg.sv]
`timescale 1ns / 1ps

package lcs_pkg;

   localparam int MAX_LEN = 64;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 8;
   localparam int FUNC_W  = 2;
   localparam int LEN_W   = 7;

   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FEED   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FEED,
      ST_FINISH
   } state_type;

endpackage

[design/lcs_length_engine.sv]
`timescale 1ns / 1ps

// A load passes through ST_LOAD (skipped when the store is full), and a feed stays in ST_FEED
// for each stored first-sequence symbol (one score-row entry per cycle through one compare/max
// unit), a finish passes through ST_FINISH and rsp_strobe is high in the cycle after the transfer.
// A new transfer is accepted only while busy is low; results cannot be stalled by the receiver.
// Reset clears the fill count and overflow flag; the stores need no clearing pass.
module lcs_length_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lcs_pkg::FUNC_W-1:0]  req_func,
   input  logic [lcs_pkg::SYM_W-1:0]   req_symbol,
   output logic                        rsp_strobe,
   output logic [lcs_pkg::LEN_W-1:0]   rsp_lcs_length,
   output logic                        rsp_overflowed
);
   import lcs_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [CNT_W-1:0]  diag_ff, diag_in;
   logic [CNT_W-1:0]  left_ff, left_in;

   logic [SYM_W-1:0]  sym_mem [MAX_LEN];
   logic [CNT_W-1:0]  score_mem [MAX_LEN];
   logic [SYM_W-1:0]  sym_rd_ff;
   logic [CNT_W-1:0]  score_rd_ff;

   logic              accept;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_score;
   logic              sym_wr_en;
   logic [CNT_W-1:0]  cell_next;
   logic [CNT_W-1:0]  last_idx;
   logic              feed_last;

   assign accept    = start && (state_ff == ST_IDLE);
   assign last_idx  = count_ff - CNT_W'(1);
   assign feed_last = (CNT_W'(idx_ff) == last_idx);

   // shared compare / max unit
   always_comb begin
      if (sym_rd_ff == sym_ff) begin
         cell_next = diag_ff + CNT_W'(1);
      end else if (left_ff > score_rd_ff) begin
         cell_next = left_ff;
      end else begin
         cell_next = score_rd_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_LOAD) begin
                  if (count_ff < CNT_W'(MAX_LEN)) begin
                     state_in = ST_LOAD;
                  end
               end else if (req_func == FUNC_FEED) begin
                  if (count_ff != '0) begin
                     state_in = ST_FEED;
                  end
               end else if (req_func == FUNC_FINISH) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOAD:   state_in = ST_IDLE;
         ST_FEED: begin
            if (feed_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      busy           = 1'b1;
      rsp_strobe     = 1'b0;
      rsp_lcs_length = '0;
      rsp_overflowed = ovf_ff;
      rd_addr        = last_idx[ADDR_W-1:0];
      wr_en          = 1'b0;
      sym_wr_en      = 1'b0;
      wr_addr        = idx_ff;
      wr_score       = cell_next;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      idx_in         = idx_ff;
      sym_in         = sym_ff;
      diag_in        = diag_ff;
      left_in        = left_ff;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req_func == FUNC_FEED) begin
               rd_addr = '0;
            end
            if (accept) begin
               sym_in  = req_symbol;
               idx_in  = '0;
               diag_in = '0;
               left_in = '0;
               if ((req_func == FUNC_LOAD) && (count_ff >= CNT_W'(MAX_LEN))) begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            wr_en     = 1'b1;
            sym_wr_en = 1'b1;
            wr_addr   = count_ff[ADDR_W-1:0];
            wr_score  = (count_ff == '0) ? '0 : score_rd_ff;
            count_in  = count_ff + CNT_W'(1);
         end
         ST_FEED: begin
            wr_en   = 1'b1;
            rd_addr = idx_ff + ADDR_W'(1);
            diag_in = score_rd_ff;
            left_in = cell_next;
            idx_in  = idx_ff + ADDR_W'(1);
         end
         ST_FINISH: begin
            rsp_strobe = 1'b1;
            if (count_ff != '0) begin
               rsp_lcs_length = (score_rd_ff > CNT_W'((1 << LEN_W) - 1)) ?
                                '1 : LEN_W'(score_rd_ff);
            end
            count_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sym_ff  <= sym_in;
      diag_ff <= diag_in;
      left_ff <= left_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem[wr_addr] <= wr_score;
      end
      score_rd_ff <= score_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sym_wr_en) begin
         sym_mem[wr_addr] <= sym_ff;
      end
      sym_rd_ff <= sym_mem[rd_addr];
   end

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside busy window");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LEN))
      else $error("fill count beyond capacity");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (count_ff == '0) && !ovf_ff)
      else $error("store not cleared after finish");

   a_feed_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("feed index past fill count");

endmodule
